[sv/curve_sample_reducer_assert.svh]
// Assertion macros for the curve sample reducer.
`ifndef CURVE_SAMPLE_REDUCER_ASSERT_SVH
`define CURVE_SAMPLE_REDUCER_ASSERT_SVH
`ifndef SYNTHESIS
`define CSR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CSR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CSR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/csr_pkg.sv]
// Shared types and constants of the curve sample reducer.
package csr_pkg;
  localparam int unsigned DataW = 16;
  localparam int unsigned OutIdxW = 6;

  typedef struct packed {
    logic load;      // store the input item
    logic seg_init;  // push the whole set as first segment
    logic pop;       // pop a segment and latch its ends
    logic scan_init; // start the interior scan
    logic scan_fire; // latch an end, or start the divider for the current interior sample
    logic scan_acc;  // fold the quotient into the best error
    logic split;     // mark best and push halves
    logic emit_init; // start the output walk
    logic emit_step; // advance the output walk
    logic clear;     // clear marks and counts for the next set
  } csr_cmd_t;

  typedef struct packed {
    logic stack_empty;
    logic seg_short;
    logic scan_done;
    logic div_busy;
    logic found;
    logic emit_done;
    logic emit_skip;
    logic clear_done;
  } csr_stat_t;
endpackage

[sv/csr_div.sv]
// Radix-2 signed divider, one quotient bit per cycle, truncating toward zero.
module csr_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic signed [33:0] num_i,
  input  logic signed [16:0] den_i,
  output logic        busy_o,
  output logic signed [33:0] quo_o
);
  logic [33:0] rem_q, rem_d, quo_q, quo_d;
  logic [16:0] den_q;
  logic        neg_q;
  logic [5:0]  cnt_q;
  logic [34:0] trial;

  assign trial = {rem_q, quo_q[33]} - {18'd0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= 6'd34;
    end else if (cnt_q != 6'd0) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (!trial[34]) begin
      rem_d = trial[33:0];
      quo_d = {quo_q[32:0], 1'b1};
    end else begin
      rem_d = {rem_q[32:0], quo_q[33]};
      quo_d = {quo_q[32:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i[33] ? 34'(-num_i) : num_i;
      den_q <= den_i[16] ? 17'(-den_i) : den_i;
      neg_q <= num_i[33] ^ den_i[16];
    end else if (cnt_q != 6'd0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = (cnt_q != 6'd0) || start_i;
  assign quo_o  = neg_q ? 34'(-quo_q) : quo_q;
endmodule

[sv/csr_datapath.sv]
// Sample stores, segment stack, error scan and output walk.
module csr_datapath #(
  parameter int unsigned MaxSamples = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  csr_pkg::csr_cmd_t   cmd_i,
  output csr_pkg::csr_stat_t  stat_o,
  input  logic [15:0]         limit_i,
  input  logic [15:0]         in_param_i,
  input  logic [15:0]         in_value_i,
  output logic [15:0]         out_param_o,
  output logic [15:0]         out_value_o,
  output logic [5:0]          out_index_o,
  output logic                out_overflow_o,
  output logic                out_last_o
);
  import csr_pkg::*;
  localparam int unsigned IdxW = $clog2(MaxSamples);
  localparam int unsigned CntW = IdxW + 1;

  logic [15:0] param_mem [MaxSamples];
  logic [15:0] value_mem [MaxSamples];
  logic [2*IdxW-1:0] stack_mem [MaxSamples];
  logic [MaxSamples-1:0] keep_q;
  logic [CntW-1:0] count_q, sp_q;
  logic ovf_q;
  logic [IdxW-1:0] a_q, b_q, i_q, best_i_q, rd_addr;
  logic [15:0] rd_param_q, rd_value_q;
  logic [15:0] t0_q, v0_q, v2_q, t2_q, v1_q;
  logic [34:0] best_err_q;
  logic found_q;
  logic first_q;
  logic [2*IdxW-1:0] top_q;
  logic [1:0] phase_q;
  logic div_busy;
  logic signed [33:0] num, quo;
  logic signed [16:0] den;
  logic signed [34:0] err;
  logic [34:0] aerr;
  logic [IdxW-1:0] n_last;
  logic acc_en, lo_push, hi_push, emit_end;

  assign n_last = IdxW'(count_q - CntW'(1));

  // fold a quotient only once both ends are latched
  assign acc_en = cmd_i.scan_acc && (phase_q == 2'd3);

  // push a half only if it still has an interior sample
  assign lo_push = CntW'(best_i_q) >= CntW'(a_q) + CntW'(2);
  assign hi_push = CntW'(b_q) >= CntW'(best_i_q) + CntW'(2);

  // read port: address chosen per phase
  always_comb begin
    rd_addr = i_q;
    if (cmd_i.pop) rd_addr = '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && count_q < CntW'(MaxSamples)) begin
      param_mem[count_q[IdxW-1:0]] <= in_param_i;
      value_mem[count_q[IdxW-1:0]] <= in_value_i;
    end
    rd_param_q <= param_mem[rd_addr];
    rd_value_q <= value_mem[rd_addr];
  end

  // after a pop, the phase counter reads end a, then end b
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; ovf_q <= 1'b0; sp_q <= '0; keep_q <= '0;
      found_q <= 1'b0; first_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (count_q < CntW'(MaxSamples)) count_q <= count_q + CntW'(1);
        else ovf_q <= 1'b1;
      end
      if (cmd_i.seg_init) sp_q <= (count_q >= CntW'(3)) ? CntW'(1) : '0;
      if (cmd_i.pop) sp_q <= sp_q - CntW'(1);
      if (cmd_i.scan_init) found_q <= 1'b0;
      if (acc_en && aerr > {19'd0, limit_i} && aerr > best_err_q)
        found_q <= 1'b1;
      if (cmd_i.split) begin
        keep_q[best_i_q] <= 1'b1;
        sp_q <= sp_q + CntW'(lo_push) + CntW'(hi_push);
      end
      if (cmd_i.emit_init) first_q <= 1'b1;
      if (cmd_i.emit_step) first_q <= 1'b0;
      if (cmd_i.clear) begin
        keep_q <= '0; count_q <= '0; ovf_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seg_init) stack_mem[0] <= {n_last, IdxW'(0)};
    if (cmd_i.split) begin
      if (lo_push) begin
        stack_mem[sp_q[IdxW-1:0]] <= {best_i_q, a_q};
        if (hi_push)
          stack_mem[IdxW'(sp_q + CntW'(1))] <= {b_q, best_i_q};
      end else if (hi_push) begin
        stack_mem[sp_q[IdxW-1:0]] <= {b_q, best_i_q};
      end
    end
    if (cmd_i.pop) top_q <= stack_mem[IdxW'(sp_q - CntW'(1))];
  end

  // scan: i_q walks the interior; phase 0 latches a, 1 latches b
  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      i_q <= '0;
    end
    if (cmd_i.scan_init) begin
      a_q <= top_q[IdxW-1:0];
      b_q <= top_q[2*IdxW-1:IdxW];
      i_q <= top_q[IdxW-1:0];
      best_err_q <= '0;
    end
    if (cmd_i.scan_fire) begin
      case (phase_q)
        2'd0: begin t0_q <= rd_param_q; v0_q <= rd_value_q; i_q <= b_q; end
        2'd1: begin t2_q <= rd_param_q; v2_q <= rd_value_q; i_q <= a_q + IdxW'(1); end
        default: begin v1_q <= rd_value_q; end
      endcase
    end
    if (acc_en) begin
      if (aerr > {19'd0, limit_i} && aerr > best_err_q) begin
        best_err_q <= aerr;
        best_i_q <= i_q;
      end
      i_q <= i_q + IdxW'(1);
    end
    if (cmd_i.emit_init) i_q <= '0;
    // a lone sample is walked twice at index 0
    if (cmd_i.emit_step) i_q <= (count_q == CntW'(1)) ? i_q : i_q + IdxW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) phase_q <= '0;
    else if (cmd_i.scan_init) phase_q <= '0;
    else if (cmd_i.scan_fire && phase_q != 2'd3) phase_q <= phase_q + 2'd1;
  end

  assign den = $signed({1'b0, t2_q}) - $signed({1'b0, t0_q});
  assign num = 34'($signed({{17{v2_q[15]}}, v2_q}) - $signed({{17{v0_q[15]}}, v0_q}))
             * 34'($signed({1'b0, rd_param_q}) - $signed({1'b0, t0_q}));

  csr_div u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.scan_fire && phase_q[1] && den != 17'sd0),
    .num_i(num), .den_i(den), .busy_o(div_busy), .quo_o(quo)
  );

  assign err = (den == 17'sd0 ? 35'($signed(v0_q)) : 35'(quo) + 35'($signed(v0_q)))
             - 35'($signed(v1_q));
  assign aerr = err[34] ? 35'(-err) : err;

  assign emit_end = (CntW'(i_q) >= count_q - CntW'(1)) && !(first_q && count_q == CntW'(1));

  assign stat_o.stack_empty = (sp_q == '0);
  assign stat_o.seg_short   = (CntW'(top_q[2*IdxW-1:IdxW]) < CntW'(top_q[IdxW-1:0]) + CntW'(2));
  assign stat_o.scan_done   = phase_q[1] && (i_q >= b_q);
  assign stat_o.div_busy    = div_busy;
  assign stat_o.found       = found_q;
  assign stat_o.emit_done   = emit_end;
  assign stat_o.emit_skip   = (i_q != '0) && !keep_q[i_q];
  assign stat_o.clear_done  = 1'b1;

  assign out_param_o    = rd_param_q;
  assign out_value_o    = rd_value_q;
  assign out_index_o    = 6'(i_q);
  assign out_overflow_o = ovf_q;
  assign out_last_o     = emit_end;
endmodule

[sv/csr_ctrl.sv]
// Sequencer for load, split and emit phases.
module csr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  logic               in_last_i,
  input  logic               out_ready_i,
  input  csr_pkg::csr_stat_t stat_i,
  output csr_pkg::csr_cmd_t  cmd_o,
  output logic               in_ready_o,
  output logic               out_valid_o
);
  import csr_pkg::*;
  localparam logic [3:0] S_LOAD = 4'd0, S_POP = 4'd1, S_TOP = 4'd2, S_RD = 4'd3,
    S_FIRE = 4'd4, S_WAIT = 4'd5, S_SPLIT = 4'd6, S_EMIT = 4'd7, S_ERD = 4'd8,
    S_OUT = 4'd9, S_INIT = 4'd10, S_WAIT2 = 4'd11;
  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_LOAD;
    else state_q <= state_d;
  end

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    in_ready_o = (state_q == S_LOAD);
    out_valid_o = (state_q == S_OUT);
    case (state_q)
      S_LOAD: if (in_fire_i) begin
        cmd_o.load = 1'b1;
        if (in_last_i) state_d = S_INIT;
      end
      S_INIT: begin cmd_o.seg_init = 1'b1; state_d = S_POP; end
      S_POP: if (stat_i.stack_empty) begin
        cmd_o.emit_init = 1'b1; state_d = S_ERD;
      end else begin
        cmd_o.pop = 1'b1; state_d = S_TOP;
      end
      S_TOP: if (stat_i.seg_short) state_d = S_POP;
             else begin cmd_o.scan_init = 1'b1; state_d = S_RD; end
      S_RD: state_d = S_FIRE;
      S_FIRE: begin
        if (stat_i.scan_done) state_d = S_SPLIT;
        else begin cmd_o.scan_fire = 1'b1; state_d = S_WAIT; end
      end
      S_WAIT: state_d = S_WAIT2;
      S_WAIT2: if (!stat_i.div_busy) begin
        // third fire starts the divide; the first two latch the ends
        cmd_o.scan_acc = 1'b0;
        state_d = S_EMIT;
      end
      S_EMIT: begin cmd_o.scan_acc = 1'b1; state_d = S_RD; end
      S_SPLIT: begin
        if (stat_i.found) cmd_o.split = 1'b1;
        state_d = S_POP;
      end
      S_ERD: state_d = stat_i.emit_skip && !stat_i.emit_done ? S_ERD : S_OUT;
      S_OUT: if (out_ready_i) begin
        if (stat_i.emit_done) begin cmd_o.clear = 1'b1; state_d = S_LOAD; end
        else begin cmd_o.emit_step = 1'b1; state_d = S_ERD; end
      end
      default: state_d = S_LOAD;
    endcase
    if (state_q == S_ERD && stat_i.emit_skip && !stat_i.emit_done) cmd_o.emit_step = 1'b1;
  end
endmodule

[sv/curve_sample_reducer.sv]
// Top level of the curve sample reducer: stream ports, controller and datapath.
// Loading accepts one item per cycle. The last item starts the split pass, which runs
// the 34-step bit-serial divider for each interior sample unless the segment's
// end parameters are equal.
// Emitting walks the stored samples and skips those that were not retained.
// rst_ni clears controller, counts, marks and limit at once; stores and stack keep none.
`include "curve_sample_reducer_assert.svh"
module curve_sample_reducer #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample_param[15:0], sample_value[31:16]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_param, out_value, out_index, overflow
  output logic        m_axis_tlast
);
  import csr_pkg::*;
  csr_cmd_t cmd;
  csr_stat_t stat;
  logic [15:0] limit_q, op, ov;
  logic [5:0] oi;
  logic oo, ol;
  logic out_end;

  // hold the limit until software rewrites it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= '0;
    else if (cfg_we_i) limit_q <= cfg_wdata_i;
  end

  csr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(s_axis_tvalid && s_axis_tready), .in_last_i(s_axis_tlast),
    .out_ready_i(m_axis_tready), .stat_i(stat), .cmd_o(cmd),
    .in_ready_o(s_axis_tready), .out_valid_o(m_axis_tvalid)
  );

  csr_datapath #(.MaxSamples(MAX_SAMPLES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .limit_i(limit_q),
    .in_param_i(s_axis_tdata[15:0]), .in_value_i(s_axis_tdata[31:16]),
    .out_param_o(op), .out_value_o(ov), .out_index_o(oi),
    .out_overflow_o(oo), .out_last_o(ol)
  );

  assign m_axis_tdata = {1'b0, oo, oi, ov, op};
  assign m_axis_tlast = ol;

  assign out_end = m_axis_tvalid && m_axis_tready && m_axis_tlast;

  `CSR_ASSERT_IMPL(a_no_both, clk_i, rst_ni, 1'b1, !(s_axis_tready && m_axis_tvalid))
  `CSR_ASSERT_NEXT(a_last_back, clk_i, rst_ni, out_end, s_axis_tready)
endmodule
